// File: sv/akf_pkg.sv
// akf_pkg: shared constants for the altitude kalman filter
// no dependencies
`timescale 1ns / 1ps
package akf_pkg;
    localparam int DT_FRAC = 16;
    localparam int DT_WIDTH = 16;
    localparam int NOISE_WIDTH = 31;
    localparam int IDX_WIDTH = 2;
    localparam logic [IDX_WIDTH-1:0] REG_DT = 2'd0;
    localparam logic [IDX_WIDTH-1:0] REG_QALT = 2'd1;
    localparam logic [IDX_WIDTH-1:0] REG_QVEL = 2'd2;
    localparam logic [IDX_WIDTH-1:0] REG_RNOISE = 2'd3;
endpackage

// File: sv/akf_stream_if.sv
// akf_stream_if: valid/ready channel carrying two signed words
// depends on nothing
`timescale 1ns / 1ps
interface akf_stream_if #(parameter int W = 32);
    logic valid;
    logic ready;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    modport source (output valid, output a, output b, input ready);
    modport sink (input valid, input a, input b, output ready);
endinterface

// File: sv/altitude_kalman_filter.sv
// altitude_kalman_filter: two-state altitude / velocity kalman filter
// depends on akf_pkg and akf_stream_if
//
// channel  | dir | payload
// in_ch    | in  | a = accel_z, b = baro_alt
// out_ch   | out | a = altitude, b = velocity
// cfg      | in  | cfg_we, cfg_index, cfg_data
//
// one step runs on a sequencer of ops through one shared multiplier,
// one shared saturating adder and a shift-subtract divider that forms each gain.
// reset clears state, covariance and config to their reset values.
// in_ch.ready is low while a step runs; a finished step waits in S_OUT while the
// previous result is still held, and a result holds until out_ch transfers it.
`timescale 1ns / 1ps
module altitude_kalman_filter #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [akf_pkg::IDX_WIDTH-1:0] cfg_index,
    input  logic [akf_pkg::NOISE_WIDTH-1:0] cfg_data,
    akf_stream_if.sink   in_ch,
    akf_stream_if.source out_ch
);
    import akf_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int MW = 2 * W;
    localparam int QW = W + 2;
    localparam int CW = $clog2(W + FRAC_BITS + 1) + 1;
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE =
        (FRAC_BITS >= W - 1) ? SMAX : W'(64'(1) << FRAC_BITS);

    typedef enum logic [5:0] {
        S_IDLE, S_ADT, S_VDT, S_ALT1, S_ADT2, S_ALT2, S_VELP,
        S_M11, S_Q01, S_Q10, S_M10, S_Q00A, S_M01, S_Q00B, S_Q00C, S_Q11,
        S_S, S_D0, S_D1, S_ERR, S_MK0, S_EALT, S_MK1, S_EVEL, S_OMK,
        S_C0, S_C1, S_M2, S_C2, S_M3, S_C3, S_OUT
    } state_t;

    state_t state_reg;
    logic [DT_WIDTH-1:0] dt_reg;
    logic [NOISE_WIDTH-1:0] qa_reg, qv_reg, rn_reg;
    logic signed [W-1:0] ealt_reg, evel_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [W-1:0] acc_reg, baro_reg, adt_reg, altp_reg, velp_reg, t_reg;
    logic signed [W-1:0] q00_reg, q01_reg, q10_reg, q11_reg, s_reg;
    logic signed [W-1:0] k0_reg, k1_reg, err_reg, omk_reg;
    logic signed [W-1:0] oa_reg, ob_reg;
    logic out_valid_reg;
    logic out_load;

    // divider state
    logic div_busy_reg, div_sel_reg, div_neg_reg, div_ovf_reg;
    logic [CW-1:0] div_cnt_reg;
    logic [W+FRAC_BITS-1:0] div_num_reg;
    logic [W:0] div_rem_reg;
    logic [QW-1:0] div_q_reg;
    logic [W-1:0] div_den_reg;

    function automatic logic signed [W-1:0] noise(input logic [NOISE_WIDTH-1:0] r);
        logic [63:0] v;
        v = 64'(r);
        if (v > 64'(SMAX)) return SMAX;
        return W'(v);
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? W'(-x) : W'(x);
    endfunction

    function automatic logic signed [W-1:0] from_mag(input logic neg,
        input logic [MW:0] m);
        if (neg)
        begin
            if (m >= (MW+1)'(SMAX) + 1'b1) return SMIN;
            return W'(-m);
        end
        if (m > (MW+1)'(SMAX)) return SMAX;
        return W'(m);
    endfunction

    // shared saturating adder
    logic signed [W-1:0] add_a, add_b, add_y;
    logic add_sub;
    logic signed [W:0] add_w;
    always_comb
    begin
        add_w = add_sub ? ((W+1)'(add_a) - (W+1)'(add_b))
                        : ((W+1)'(add_a) + (W+1)'(add_b));
        if (add_w[W] != add_w[W-1]) add_y = add_w[W] ? SMIN : SMAX;
        else add_y = add_w[W-1:0];
    end

    // shared multiplier: magnitude product, shift, saturate
    logic signed [W-1:0] mul_a, mul_b, mul_y;
    logic mul_dt;
    logic [MW-1:0] mul_p, mul_s;
    always_comb
    begin
        mul_p = MW'(mag(mul_a)) * MW'(mag(mul_b));
        mul_s = mul_dt ? (mul_p >> DT_FRAC) : (mul_p >> FRAC_BITS);
        mul_y = from_mag(mul_a[W-1] != mul_b[W-1], {1'b0, mul_s});
    end

    logic signed [W-1:0] dtw;
    assign dtw = W'({1'b0, dt_reg});

    // operand selection per step
    always_comb
    begin
        add_a = '0; add_b = '0; add_sub = 1'b0;
        mul_a = '0; mul_b = dtw; mul_dt = 1'b1;
        case (state_reg)
            S_ADT:  mul_a = acc_reg;
            S_VDT:  mul_a = evel_reg;
            S_ALT1: begin add_a = ealt_reg; add_b = t_reg; end
            S_ADT2: mul_a = adt_reg;
            S_ALT2: begin add_a = altp_reg; add_b = t_reg; end
            S_VELP: begin add_a = evel_reg; add_b = adt_reg; end
            S_M11:  mul_a = p11_reg;
            S_Q01:  begin add_a = p01_reg; add_b = t_reg; end
            S_Q10:  begin add_a = p10_reg; add_b = t_reg; end
            S_M10:  mul_a = p10_reg;
            S_Q00A: begin add_a = p00_reg; add_b = t_reg; end
            S_M01:  mul_a = q01_reg;
            S_Q00B: begin add_a = q00_reg; add_b = t_reg; end
            S_Q00C: begin add_a = q00_reg; add_b = noise(qa_reg); end
            S_Q11:  begin add_a = p11_reg; add_b = noise(qv_reg); end
            S_S:    begin add_a = q00_reg; add_b = noise(rn_reg); end
            S_ERR:  begin add_a = baro_reg; add_b = altp_reg; add_sub = 1'b1; end
            S_MK0:  begin mul_a = k0_reg; mul_b = err_reg; mul_dt = 1'b0; end
            S_EALT: begin add_a = altp_reg; add_b = t_reg; end
            S_MK1:  begin mul_a = k1_reg; mul_b = err_reg; mul_dt = 1'b0; end
            S_EVEL: begin add_a = velp_reg; add_b = t_reg; end
            S_OMK:  begin add_a = ONE; add_b = k0_reg; add_sub = 1'b1; end
            S_C0:   begin mul_a = omk_reg; mul_b = q00_reg; mul_dt = 1'b0; end
            S_C1:   begin mul_a = omk_reg; mul_b = q01_reg; mul_dt = 1'b0; end
            S_M2:   begin mul_a = k1_reg; mul_b = q00_reg; mul_dt = 1'b0; end
            S_C2:   begin add_a = q10_reg; add_b = t_reg; add_sub = 1'b1; end
            S_M3:   begin mul_a = k1_reg; mul_b = q01_reg; mul_dt = 1'b0; end
            S_C3:   begin add_a = q11_reg; add_b = t_reg; add_sub = 1'b1; end
            default: ;
        endcase
    end

    // divider step: restoring, one quotient bit a cycle
    logic [W:0] dv_r;
    logic dv_qb;
    logic [W-1:0] lim;
    logic [QW-1:0] dv_q;
    logic dv_of;
    logic signed [W-1:0] div_y;
    always_comb
    begin
        lim = div_neg_reg ? W'(SMAX) + 1'b1 : W'(SMAX);
        dv_r = {div_rem_reg[W-1:0], div_num_reg[W+FRAC_BITS-1]};
        dv_qb = dv_r >= (W+1)'(div_den_reg);
        if (dv_qb) dv_r = dv_r - (W+1)'(div_den_reg);
        dv_q = {div_q_reg[QW-2:0], dv_qb};
        dv_of = (div_q_reg > QW'(lim >> 1)) || (dv_q > QW'(lim));
        div_y = from_mag(div_neg_reg, (MW+1)'(div_q_reg));
        if (div_ovf_reg) div_y = div_neg_reg ? SMIN : SMAX;
    end

    // a finished step moves to the output register once it is free
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.a = oa_reg;
    assign out_ch.b = ob_reg;

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dt_reg <= DT_WIDTH'(655);
            qa_reg <= '0; qv_reg <= '0; rn_reg <= '0;
            ealt_reg <= '0; evel_reg <= '0;
            p00_reg <= '0; p01_reg <= '0; p10_reg <= '0; p11_reg <= '0;
            out_valid_reg <= 1'b0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DT:     dt_reg <= cfg_data[DT_WIDTH-1:0];
                    REG_QALT:   qa_reg <= cfg_data;
                    REG_QVEL:   qv_reg <= cfg_data;
                    REG_RNOISE: rn_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (in_ch.valid && in_ch.ready)
                begin
                    acc_reg <= in_ch.a; baro_reg <= in_ch.b;
                    state_reg <= S_ADT;
                end
                S_ADT:  begin adt_reg <= mul_y; state_reg <= S_VDT; end
                S_VDT:  begin t_reg <= mul_y; state_reg <= S_ALT1; end
                S_ALT1: begin altp_reg <= add_y; state_reg <= S_ADT2; end
                S_ADT2:
                begin
                    t_reg <= mul_y / 2;
                    state_reg <= S_ALT2;
                end
                S_ALT2: begin altp_reg <= add_y; state_reg <= S_VELP; end
                S_VELP: begin velp_reg <= add_y; state_reg <= S_M11; end
                S_M11:  begin t_reg <= mul_y; state_reg <= S_Q01; end
                S_Q01:  begin q01_reg <= add_y; state_reg <= S_Q10; end
                S_Q10:  begin q10_reg <= add_y; state_reg <= S_M10; end
                S_M10:  begin t_reg <= mul_y; state_reg <= S_Q00A; end
                S_Q00A: begin q00_reg <= add_y; state_reg <= S_M01; end
                S_M01:  begin t_reg <= mul_y; state_reg <= S_Q00B; end
                S_Q00B: begin q00_reg <= add_y; state_reg <= S_Q00C; end
                S_Q00C: begin q00_reg <= add_y; state_reg <= S_Q11; end
                S_Q11:  begin q11_reg <= add_y; state_reg <= S_S; end
                S_S:
                begin
                    s_reg <= (add_y == '0) ? W'(1) : add_y;
                    state_reg <= S_D0;
                end
                S_D0, S_D1:
                begin
                    if (!div_busy_reg)
                    begin
                        // load divider with numerator q00 or q10
                        div_sel_reg <= (state_reg == S_D1);
                        div_num_reg <= {mag(state_reg == S_D1 ? q10_reg : q00_reg),
                                        FRAC_BITS'(0)};
                        div_neg_reg <= (state_reg == S_D1 ? q10_reg[W-1] : q00_reg[W-1])
                                       != s_reg[W-1];
                        div_den_reg <= mag(s_reg);
                        div_rem_reg <= '0;
                        div_q_reg <= '0;
                        div_ovf_reg <= 1'b0;
                        div_cnt_reg <= CW'(W + FRAC_BITS);
                        div_busy_reg <= 1'b1;
                    end
                    else if (div_cnt_reg == '0 || div_ovf_reg)
                    begin
                        if (div_sel_reg) k1_reg <= div_y; else k0_reg <= div_y;
                        div_busy_reg <= 1'b0;
                        state_reg <= div_sel_reg ? S_ERR : S_D1;
                    end
                    else
                    begin
                        div_num_reg <= div_num_reg << 1;
                        div_rem_reg <= dv_r;
                        div_cnt_reg <= div_cnt_reg - 1'b1;
                        if (dv_of) div_ovf_reg <= 1'b1;
                        else div_q_reg <= dv_q;
                    end
                end
                S_ERR:  begin err_reg <= add_y; state_reg <= S_MK0; end
                S_MK0:  begin t_reg <= mul_y; state_reg <= S_EALT; end
                S_EALT: begin ealt_reg <= add_y; state_reg <= S_MK1; end
                S_MK1:  begin t_reg <= mul_y; state_reg <= S_EVEL; end
                S_EVEL: begin evel_reg <= add_y; state_reg <= S_OMK; end
                S_OMK:  begin omk_reg <= add_y; state_reg <= S_C0; end
                S_C0:   begin p00_reg <= mul_y; state_reg <= S_C1; end
                S_C1:   begin p01_reg <= mul_y; state_reg <= S_M2; end
                S_M2:   begin t_reg <= mul_y; state_reg <= S_C2; end
                S_C2:   begin p10_reg <= add_y; state_reg <= S_M3; end
                S_M3:   begin t_reg <= mul_y; state_reg <= S_C3; end
                S_C3:   begin p11_reg <= add_y; state_reg <= S_OUT; end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        oa_reg <= ealt_reg; ob_reg <= evel_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("input ready while busy");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(oa_reg)))
        else $error("result dropped under stall");
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> (state_reg == S_D0 || state_reg == S_D1))
        else $error("divider busy outside divide steps");
    a_s_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D0) |-> (s_reg != '0))
        else $error("zero divisor");
endmodule

// File: test/altitude_kalman_filter_test.sv
// altitude_kalman_filter_test: self-checking bench for the altitude / velocity kalman filter
// depends on akf_pkg, akf_stream_if and altitude_kalman_filter
`timescale 1ns / 1ps
module altitude_kalman_filter_test;
    import akf_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int DRAIN_CYCLES = 160;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_STALL = 400;

    typedef struct {
        logic signed [DW-1:0] altitude;
        logic signed [DW-1:0] velocity;
    } estimate_t;

    typedef struct {
        logic signed [DW-1:0] accel;
        logic signed [DW-1:0] baro;
        bit                   typed;
        logic signed [DW-1:0] alt_exp;
        logic signed [DW-1:0] vel_exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_WIDTH-1:0] cfg_index = REG_DT;
    logic [NOISE_WIDTH-1:0] cfg_data = '0;

    akf_stream_if #(.W(DW)) in_ch ();
    akf_stream_if #(.W(DW)) out_ch ();

    altitude_kalman_filter #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always #4 clk = ~clk;

    // predictor copy of filter state and registers
    longint period_q;
    longint qalt_q;
    longint qvel_q;
    longint rnoise_q;
    longint alt_est;
    longint vel_est;
    longint cov [4];

    estimate_t estimate_q [$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int phases_run = 0;
    bit long_hold = 1'b0;
    bit calm = 1'b0;

    function automatic longint clamp(longint x);
        if (x > SMAX) return SMAX;
        if (x < SMIN) return SMIN;
        return x;
    endfunction

    // product with magnitude truncated by the fraction shift, then saturated
    function automatic longint mulq(longint a, longint b, int sh);
        logic [63:0] ma, mb, p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb) >> sh;
        if ((a < 0) != (b < 0)) return (p >= 64'd2147483648) ? SMIN : -longint'(p);
        return (p > 64'd2147483647) ? SMAX : longint'(p);
    endfunction

    function automatic longint divq(longint num, longint den);
        logic [63:0] mn, md, q;
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = (mn << FB) / md;
        if ((num < 0) != (den < 0)) return (q >= 64'd2147483648) ? SMIN : -longint'(q);
        return (q > 64'd2147483647) ? SMAX : longint'(q);
    endfunction

    // one fused predict / correct step
    function automatic estimate_t fuse_step(logic signed [DW-1:0] accel,
                                            logic signed [DW-1:0] baro);
        longint acc, bar, a_dt, alt_p, vel_p, q00, q01, q10, q11, s, k0, k1, err, omk;
        estimate_t r;
        acc = accel;
        bar = baro;
        a_dt = mulq(acc, period_q, DT_FRAC);
        alt_p = clamp(alt_est + mulq(vel_est, period_q, DT_FRAC));
        alt_p = clamp(alt_p + mulq(a_dt, period_q, DT_FRAC) / 2);
        vel_p = clamp(vel_est + a_dt);
        q01 = clamp(cov[1] + mulq(cov[3], period_q, DT_FRAC));
        q10 = clamp(cov[2] + mulq(cov[3], period_q, DT_FRAC));
        q00 = clamp(cov[0] + mulq(cov[2], period_q, DT_FRAC));
        q00 = clamp(q00 + mulq(q01, period_q, DT_FRAC));
        q00 = clamp(q00 + qalt_q);
        q11 = clamp(cov[3] + qvel_q);
        s = clamp(q00 + rnoise_q);
        if (s == 0)
            s = 1;
        k0 = divq(q00, s);
        k1 = divq(q10, s);
        err = clamp(bar - alt_p);
        alt_est = clamp(alt_p + mulq(k0, err, FB));
        vel_est = clamp(vel_p + mulq(k1, err, FB));
        omk = clamp((longint'(1) << FB) - k0);
        cov[0] = mulq(omk, q00, FB);
        cov[1] = mulq(omk, q01, FB);
        cov[2] = clamp(q10 - mulq(k1, q00, FB));
        cov[3] = clamp(q11 - mulq(k1, q01, FB));
        r.altitude = alt_est[DW-1:0];
        r.velocity = vel_est[DW-1:0];
        return r;
    endfunction

    // register write, enable left high until the caller closes the burst
    task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [NOISE_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_DT:     period_q = val[DT_WIDTH-1:0];
            REG_QALT:   qalt_q = val;
            REG_QVEL:   qvel_q = val;
            REG_RNOISE: rnoise_q = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(longint dt, longint qa, longint qv, longint rn);
        write_reg(REG_DT, NOISE_WIDTH'(dt));
        write_reg(REG_QALT, NOISE_WIDTH'(qa));
        write_reg(REG_QVEL, NOISE_WIDTH'(qv));
        write_reg(REG_RNOISE, NOISE_WIDTH'(rn));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop offering, then wait for every result and some quiet cycles
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        wait (estimate_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offer one sample, predict on transfer
    task automatic send_sample(logic signed [DW-1:0] accel, logic signed [DW-1:0] baro,
                               bit typed, logic signed [DW-1:0] alt_x,
                               logic signed [DW-1:0] vel_x);
        int gap;
        estimate_t e;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.a <= accel;
        in_ch.b <= baro;
        do
            @(posedge clk);
        while (!in_ch.ready);
        e = fuse_step(accel, baro);
        if (typed)
        begin
            e.altitude = alt_x;
            e.velocity = vel_x;
        end
        estimate_q.push_back(e);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_random();
        logic signed [DW-1:0] accel, baro;
        if ($urandom_range(0, 3) == 0)
        begin
            accel = $urandom;
            baro = $urandom;
        end
        else
        begin
            accel = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            baro = $signed(alt_est[DW-1:0]) + $signed($urandom_range(0, 32'h0010_0000))
                   - 32'sh0008_0000;
        end
        send_sample(accel, baro, 1'b0, '0, '0);
    endtask

    // result side: random ready gaps, one long hold on request
    initial
    begin
        int gap;
        estimate_t e;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = long_hold ? LONG_STALL : (calm ? 0 : $urandom_range(0, 5));
            long_hold = 1'b0;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            received++;
            if (estimate_q.size() == 0)
            begin
                $error("unexpected transfer altitude=%0d velocity=%0d",
                       out_ch.a, out_ch.b);
                errors++;
            end
            else
            begin
                e = estimate_q.pop_front();
                if (out_ch.a !== e.altitude)
                begin
                    $error("altitude expected %0d actual %0d", e.altitude, out_ch.a);
                    errors++;
                end
                if (out_ch.b !== e.velocity)
                begin
                    $error("velocity expected %0d actual %0d", e.velocity, out_ch.b);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d results outstanding", estimate_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // directed samples, all at reset settings; first rows keep zero covariance
    stim_row_t directed [] = '{
        '{32'sh0000_0000, 32'sh7FFF_FFFF, 1'b1, 32'sh0, 32'sh0},
        '{32'sh0000_0000, 32'sh8000_0000, 1'b1, 32'sh0, 32'sh0},
        '{32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'sh0, 32'sh0},
        '{32'sh7FFF_FFFF, 32'sh0000_0000, 1'b0, 32'sh0, 32'sh0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 32'sh0, 32'sh0},
        '{32'sh8000_0000, 32'sh8000_0000, 1'b0, 32'sh0, 32'sh0},
        '{32'sh8000_0000, 32'sh0000_0000, 1'b0, 32'sh0, 32'sh0},
        '{32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, 32'sh0, 32'sh0},
        '{32'shFFFF_FFFF, 32'sh0000_0001, 1'b0, 32'sh0, 32'sh0},
        '{32'sh0001_0000, 32'sh0064_0000, 1'b0, 32'sh0, 32'sh0},
        '{32'shFFFF_0000, 32'shFF9C_0000, 1'b0, 32'sh0, 32'sh0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 32'sh0, 32'sh0},
        '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 32'sh0, 32'sh0},
        '{32'sh0009_CCCD, 32'sh0000_8000, 1'b0, 32'sh0, 32'sh0}
    };

    // dt, alt noise, vel noise, baro noise per phase
    longint phase_regs [8][4] = '{
        '{655, 655, 6554, 65536},
        '{1, 0, 0, 0},
        '{65535, 2147483647, 2147483647, 2147483647},
        '{0, 1000, 1000, 1000},
        '{65535, 0, 0, 2147483647},
        '{1, 2147483647, 0, 1},
        '{6554, 3277, 655, 13107},
        '{-1, -1, -1, -1}
    };

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.a = '0;
        in_ch.b = '0;
        period_q = 655;
        qalt_q = 0;
        qvel_q = 0;
        rnoise_q = 0;
        alt_est = 0;
        vel_est = 0;
        cov = '{0, 0, 0, 0};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_sample(directed[i].accel, directed[i].baro, directed[i].typed,
                        directed[i].alt_exp, directed[i].vel_exp);

        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            if (phase_regs[p][0] < 0)
                set_regs($urandom_range(0, 65535), $urandom_range(0, 32'h7FFF_FFFF),
                         $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF));
            else
                set_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2],
                         phase_regs[p][3]);
            phases_run++;
            for (int n = 0; n < 80; n++)
            begin
                calm = (n >= 20 && n < 35);
                if (p == 2 && n == 40)
                    long_hold = 1'b1;
                if (p == 4 && n == 40)
                begin
                    in_ch.valid <= 1'b0;
                    wait (estimate_q.size() == 0);
                    @(negedge clk);
                end
                send_random();
            end
            calm = 1'b0;
        end

        wait_drained();
        $display("%0d samples sent over %0d register settings, %0d estimates checked",
                 sent, phases_run + 1, received);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
